>>> design/cmis_pkg.sv
// ----------------------------------------------------------------------------
// cmis_pkg
// Shared types, constants and small lookup functions for the color matrix
// interpolation and saturation block.
// ----------------------------------------------------------------------------
package cmis_pkg;

	// Stream and configuration widths
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Item kinds carried on the input tuser bit
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_MID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_DARK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_BRIGHT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LOW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HIGH  = 3'd6;

	// Anchor store
	localparam int               SLOT_W       = 5;
	localparam int               ANCHOR_SLOTS = 27;
	localparam logic [SLOT_W-1:0] ANCHOR0_BASE = 5'd0;
	localparam logic [SLOT_W-1:0] ANCHOR1_BASE = 5'd9;
	localparam logic [SLOT_W-1:0] ANCHOR2_BASE = 5'd18;

	// Matrix entries
	localparam int         ENTRY_W    = 4;
	localparam int         ENTRIES    = 9;
	localparam logic [3:0] LAST_ENTRY = 4'd8;
	localparam logic [1:0] LAST_K     = 2'd2;

	// Saturation matrix constants
	localparam int         SAT_DIAG_BASE = 384;
	localparam int         SAT_OFF_BASE  = 640;
	localparam logic [7:0] SAT_UNITY     = 8'h80;
	localparam int         PRODUCT_SHIFT = 10;
	localparam int         ACC_W         = 30;
	localparam int         COEF_W        = 12;

	// Shared divider
	localparam int DIV_NUM_W  = 40;
	localparam int DIV_DEN_W  = 32;
	localparam int DIV_RADIX  = 2;
	localparam int DIV_STEPS  = DIV_NUM_W / DIV_RADIX;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Piecewise segment codes
	localparam logic [1:0] SEG_BELOW = 2'd0;
	localparam logic [1:0] SEG_LOWER = 2'd1;
	localparam logic [1:0] SEG_UPPER = 2'd2;
	localparam logic [1:0] SEG_ABOVE = 2'd3;

	typedef struct packed {
		logic             load;
		logic             capture;
		logic             lvl_mul;
		logic             lvl_fin;
		logic             div_start;
		logic             rd_hi;
		logic             ent_mul;
		logic             ent_fin;
		logic             mac_en;
		logic             emit;
		logic [ENTRY_W-1:0] idx;
		logic [1:0]       k;
	} cmis_cmd_t;

	typedef struct packed {
		logic div_done;
		logic lvl_interp;
		logic ent_interp;
		logic out_free;
	} cmis_status_t;

	function automatic logic [1:0] entry_row(input logic [ENTRY_W-1:0] idx);
		case (idx)
			4'd0, 4'd1, 4'd2: entry_row = 2'd0;
			4'd3, 4'd4, 4'd5: entry_row = 2'd1;
			default:          entry_row = 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] entry_col(input logic [ENTRY_W-1:0] idx);
		case (idx)
			4'd0, 4'd3, 4'd6: entry_col = 2'd0;
			4'd1, 4'd4, 4'd7: entry_col = 2'd1;
			default:          entry_col = 2'd2;
		endcase
	endfunction

	function automatic logic [ENTRY_W-1:0] mat_index(input logic [1:0] k,
			input logic [1:0] col);
		mat_index = {2'b00, k} * 4'd3 + {2'b00, col};
	endfunction

endpackage

>>> design/cmis_div.sv
// ----------------------------------------------------------------------------
// cmis_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cmis_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cmis_pkg::DIV_NUM_W-1:0] num,
	input  logic [cmis_pkg::DIV_DEN_W-1:0] den,
	output logic                       busy,
	output logic                       done,
	output logic [cmis_pkg::DIV_NUM_W-1:0] quot
);
	import cmis_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;

	logic [DIV_NUM_W-1:0] num_d;
	logic [DIV_NUM_W-1:0] quot_d;
	logic [DIV_DEN_W-1:0] rem_d;
	logic [DIV_DEN_W:0]   trial;

	always_comb begin
		num_d  = num_q;
		quot_d = quot_q;
		rem_d  = rem_q;
		trial  = '0;
		for (int j = 0; j < DIV_RADIX; j++) begin
			trial = {rem_d, num_d[DIV_NUM_W-1]};
			num_d = {num_d[DIV_NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_d  = DIV_DEN_W'(trial - {1'b0, den_q});
				quot_d = {quot_d[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_d  = trial[DIV_DEN_W-1:0];
				quot_d = {quot_d[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_d;
			rem_q  <= rem_d;
			quot_q <= quot_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> design/cmis_dp.sv
// ----------------------------------------------------------------------------
// cmis_dp
// Datapath: configuration registers, anchor store, interpolation operands,
// shared divider, saturation multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module cmis_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmis_pkg::cmis_cmd_t             cmd,
	output cmis_pkg::cmis_status_t          status,
	input  logic [cmis_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            cfg_we,
	input  logic [cmis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmis_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cmis_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast
);
	import cmis_pkg::*;

	// Input fields
	logic [SLOT_W-1:0]  in_slot;
	logic [15:0]        in_coef;
	logic [15:0]        in_temp;
	logic [31:0]        in_expo;

	assign in_slot = s_tdata[4:0];
	assign in_coef = s_tdata[20:5];
	assign in_temp = s_tdata[36:21];
	assign in_expo = s_tdata[68:37];

	// Configuration registers
	logic [15:0] temp_low_q, temp_mid_q, temp_high_q;
	logic [7:0]  sat_dark_q, sat_bright_q;
	logic [31:0] bright_low_q, bright_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q    <= '0;
			temp_mid_q    <= '0;
			temp_high_q   <= '0;
			sat_dark_q    <= SAT_UNITY;
			sat_bright_q  <= SAT_UNITY;
			bright_low_q  <= '0;
			bright_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_LOW:    temp_low_q    <= cfg_data[15:0];
				REG_TEMP_MID:    temp_mid_q    <= cfg_data[15:0];
				REG_TEMP_HIGH:   temp_high_q   <= cfg_data[15:0];
				REG_SAT_DARK:    sat_dark_q    <= cfg_data[7:0];
				REG_SAT_BRIGHT:  sat_bright_q  <= cfg_data[7:0];
				REG_BRIGHT_LOW:  bright_low_q  <= cfg_data;
				REG_BRIGHT_HIGH: bright_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured compute item and its piecewise segments
	logic [15:0] ct_q;
	logic [31:0] ei_q;
	logic [1:0]  tseg_q, bseg_q;
	logic [1:0]  tseg_d, bseg_d;

	always_comb begin
		if (in_temp < temp_low_q)       tseg_d = SEG_BELOW;
		else if (in_temp < temp_mid_q)  tseg_d = SEG_LOWER;
		else if (in_temp < temp_high_q) tseg_d = SEG_UPPER;
		else                            tseg_d = SEG_ABOVE;
		if (in_expo < bright_low_q)       bseg_d = SEG_BELOW;
		else if (in_expo < bright_high_q) bseg_d = SEG_LOWER;
		else                              bseg_d = SEG_ABOVE;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ct_q   <= in_temp;
			ei_q   <= in_expo;
			tseg_q <= tseg_d;
			bseg_q <= bseg_d;
		end
	end

	// Anchor store with registered read
	logic [15:0]       anchor_mem [ANCHOR_SLOTS];
	logic [15:0]       mem_rd_q;
	logic [SLOT_W-1:0] lo_base, hi_base, rd_addr;

	always_comb begin
		case (tseg_q)
			SEG_UPPER: lo_base = ANCHOR1_BASE;
			SEG_ABOVE: lo_base = ANCHOR2_BASE;
			default:   lo_base = ANCHOR0_BASE;
		endcase
		hi_base = (tseg_q == SEG_LOWER) ? ANCHOR1_BASE : ANCHOR2_BASE;
		rd_addr = (cmd.rd_hi ? hi_base : lo_base) + {1'b0, cmd.idx};
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_slot < SLOT_W'(ANCHOR_SLOTS)) begin
			anchor_mem[in_slot] <= in_coef;
		end
		mem_rd_q <= anchor_mem[rd_addr];
	end

	// Interpolation operands
	logic [15:0]          y0_q;
	logic                 neg_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic signed [8:0]  lvl_diff;
	logic [7:0]         lvl_mag;
	logic [31:0]        lvl_dx;
	logic [39:0]        lvl_prod;
	logic signed [16:0] ent_diff;
	logic [15:0]        ent_mag;
	logic [15:0]        ent_x0, ent_den;
	logic [15:0]        ent_dx;
	logic [31:0]        ent_prod;

	always_comb begin
		lvl_diff = $signed({1'b0, sat_bright_q}) - $signed({1'b0, sat_dark_q});
		lvl_mag  = lvl_diff[8] ? 8'(-lvl_diff) : lvl_diff[7:0];
		lvl_dx   = ei_q - bright_low_q;
		lvl_prod = {32'b0, lvl_mag} * {8'b0, lvl_dx};

		ent_diff = $signed({mem_rd_q[15], mem_rd_q}) - $signed({y0_q[15], y0_q});
		ent_mag  = ent_diff[16] ? 16'(-ent_diff) : ent_diff[15:0];
		ent_x0   = (tseg_q == SEG_LOWER) ? temp_low_q : temp_mid_q;
		ent_den  = (tseg_q == SEG_LOWER) ? (temp_mid_q - temp_low_q)
		                                  : (temp_high_q - temp_mid_q);
		ent_dx   = ct_q - ent_x0;
		ent_prod = {16'b0, ent_mag} * {16'b0, ent_dx};
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_hi) begin
			y0_q <= mem_rd_q;
		end
		if (cmd.lvl_mul) begin
			neg_q <= lvl_diff[8];
			num_q <= lvl_prod;
			den_q <= bright_high_q - bright_low_q;
		end else if (cmd.ent_mul) begin
			neg_q <= ent_diff[16];
			num_q <= {8'b0, ent_prod};
			den_q <= {16'b0, ent_den};
		end
	end

	// Shared divider
	logic                 div_busy, div_done;
	logic [DIV_NUM_W-1:0] div_quot;

	cmis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (den_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Saturation level and matrix coefficients
	logic [8:0]                lvl_q9, lvl_sum;
	logic [7:0]                level;
	logic [10:0]               five_l;
	logic signed [COEF_W-1:0]  diag_d, off_t, off_d;
	logic signed [COEF_W-1:0]  diag_q, off_q;

	always_comb begin
		lvl_q9  = {1'b0, div_quot[7:0]};
		lvl_sum = neg_q ? ({1'b0, sat_dark_q} - lvl_q9) : ({1'b0, sat_dark_q} + lvl_q9);
		case (bseg_q)
			SEG_BELOW: level = sat_dark_q;
			SEG_LOWER: level = lvl_sum[7:0];
			default:   level = sat_bright_q;
		endcase
		five_l = {3'b0, level} * 11'd5;
		diag_d = COEF_W'(SAT_DIAG_BASE) + $signed({1'b0, five_l});
		off_t  = COEF_W'(SAT_OFF_BASE) - $signed({1'b0, five_l});
		// Halve toward zero: negative values are rounded up before the shift.
		off_d  = off_t[COEF_W-1] ? ((off_t + COEF_W'(1)) >>> 1) : (off_t >>> 1);
	end

	always_ff @(posedge clk) begin
		if (cmd.lvl_fin) begin
			diag_q <= diag_d;
			off_q  <= off_d;
		end
	end

	// Interpolated matrix
	logic [15:0]        mat_q [ENTRIES];
	logic signed [16:0] ent_y17, ent_q17, ent_res;
	logic               ent_interp;

	assign ent_interp = (tseg_q == SEG_LOWER) || (tseg_q == SEG_UPPER);

	always_comb begin
		ent_y17 = $signed({y0_q[15], y0_q});
		ent_q17 = $signed({1'b0, div_quot[15:0]});
		if (!ent_interp)  ent_res = ent_y17;
		else if (neg_q)   ent_res = ent_y17 - ent_q17;
		else              ent_res = ent_y17 + ent_q17;
	end

	always_ff @(posedge clk) begin
		if (cmd.ent_fin) begin
			mat_q[cmd.idx] <= ent_res[15:0];
		end
	end

	// Row-by-column multiply-accumulate
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [15:0]       mac_val;
	logic signed [27:0]       mac_prod;
	logic signed [ACC_W-1:0]  mac_ext, acc_q, acc_rnd, acc_div;
	logic [15:0]              out_value;

	always_comb begin
		mac_coef = (cmd.k == entry_row(cmd.idx)) ? diag_q : off_q;
		mac_val  = $signed(mat_q[mat_index(cmd.k, entry_col(cmd.idx))]);
		mac_prod = mac_coef * mac_val;
		mac_ext  = {{(ACC_W-28){mac_prod[27]}}, mac_prod};
		// Divide by 1024 toward zero.
		acc_rnd  = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << PRODUCT_SHIFT) - 1) : ACC_W'(0));
		acc_div  = acc_rnd >>> PRODUCT_SHIFT;
		out_value = acc_div[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			acc_q <= (cmd.k == 2'd0) ? mac_ext : (acc_q + mac_ext);
		end
	end

	// Output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata_q <= {4'b0, out_value, cmd.idx};
			m_tlast_q <= (cmd.idx == LAST_ENTRY);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign status.div_done   = div_done;
	assign status.lvl_interp = (bseg_q == SEG_LOWER);
	assign status.ent_interp = ent_interp;
	assign status.out_free   = !m_tvalid_q || m_tready;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an untaken result");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tlast_q) |-> (m_tdata_q[ENTRY_W-1:0] == LAST_ENTRY))
		else $error("last flag on an entry other than the final one");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");
`endif

endmodule

>>> design/cmis_ctrl.sv
// ----------------------------------------------------------------------------
// cmis_ctrl
// Sequencer: takes items, steps level and per-entry interpolation through the
// shared divider, then runs the saturation multiply and emits nine results.
// ----------------------------------------------------------------------------
module cmis_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tuser,
	output logic                   s_tready,
	input  cmis_pkg::cmis_status_t status,
	output cmis_pkg::cmis_cmd_t    cmd
);
	import cmis_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_LVL_MUL = 4'd1;
	localparam logic [3:0] S_LVL_GO  = 4'd2;
	localparam logic [3:0] S_LVL_DIV = 4'd3;
	localparam logic [3:0] S_LVL_FIN = 4'd4;
	localparam logic [3:0] S_RD_LO   = 4'd5;
	localparam logic [3:0] S_RD_HI   = 4'd6;
	localparam logic [3:0] S_ENT_MUL = 4'd7;
	localparam logic [3:0] S_ENT_GO  = 4'd8;
	localparam logic [3:0] S_ENT_DIV = 4'd9;
	localparam logic [3:0] S_ENT_FIN = 4'd10;
	localparam logic [3:0] S_MAC     = 4'd11;
	localparam logic [3:0] S_EMIT    = 4'd12;

	logic [3:0]         state_q, state_d;
	logic [ENTRY_W-1:0] idx_q, idx_d;
	logic [1:0]         k_q, k_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.idx = idx_q;
		cmd.k   = k_q;
		state_d = state_q;
		idx_d   = idx_q;
		k_d     = k_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d = S_LVL_MUL;
					end
				end
			end
			S_LVL_MUL: begin
				cmd.lvl_mul = 1'b1;
				state_d = status.lvl_interp ? S_LVL_GO : S_LVL_FIN;
			end
			S_LVL_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_LVL_DIV;
			end
			S_LVL_DIV: begin
				if (status.div_done) state_d = S_LVL_FIN;
			end
			S_LVL_FIN: begin
				cmd.lvl_fin = 1'b1;
				idx_d = '0;
				state_d = S_RD_LO;
			end
			S_RD_LO: begin
				state_d = S_RD_HI;
			end
			S_RD_HI: begin
				cmd.rd_hi = 1'b1;
				state_d = status.ent_interp ? S_ENT_MUL : S_ENT_FIN;
			end
			S_ENT_MUL: begin
				cmd.ent_mul = 1'b1;
				state_d = S_ENT_GO;
			end
			S_ENT_GO: begin
				cmd.div_start = 1'b1;
				state_d = S_ENT_DIV;
			end
			S_ENT_DIV: begin
				if (status.div_done) state_d = S_ENT_FIN;
			end
			S_ENT_FIN: begin
				cmd.ent_fin = 1'b1;
				if (idx_q == LAST_ENTRY) begin
					idx_d = '0;
					k_d = '0;
					state_d = S_MAC;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = S_RD_LO;
				end
			end
			S_MAC: begin
				cmd.mac_en = 1'b1;
				if (k_q == LAST_K) begin
					k_d = '0;
					state_d = S_EMIT;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (idx_q == LAST_ENTRY) begin
						idx_d = '0;
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
						state_d = S_MAC;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			k_q     <= k_d;
		end
	end

endmodule

>>> design/color_matrix_interp_saturation.sv
// ----------------------------------------------------------------------------
// color_matrix_interp_saturation
// A load transaction (tuser 0) stores one coefficient of three 3x3 anchor
// matrices. A compute transaction (tuser 1) interpolates a matrix by color
// temperature and a saturation level by exposure index, applies the saturation
// matrix and emits nine entries, the ninth with tlast. Every interpolation goes
// through one shared divider that yields two quotient bits per cycle. A compute
// first sets the level, then reads the low and high anchors of each entry, then
// runs three multiply-accumulate steps and the output load for each entry; an
// interpolated level or entry also waits on the divider, and an output that is
// held off stalls the work. One item is worked on at a time; the next is
// taken as soon as the last entry sits in the output register.
// ----------------------------------------------------------------------------
module color_matrix_interp_saturation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// coef_slot[4:0], coef_value[20:5], color_temp[36:21],
	// exposure_index[68:37], zero fill [71:69]
	input  logic [cmis_pkg::IN_DATA_W-1:0]  s_tdata,
	// op: 0 load coefficient, 1 compute
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// entry_index[3:0], entry_value[19:4], zero fill [23:20]
	output logic [cmis_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [cmis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cmis_pkg::*;

	cmis_cmd_t    cmd;
	cmis_status_t status;

	cmis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cmis_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
